[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the blend core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define AWPB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AWPB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define AWPB_ASSERT(lbl, clk, rst_n, prop)
`define AWPB_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/awpb_pkg.sv]
// ----------------------------------------------------------------------------
// Blend core package
// Widths, constants and the pipeline payload type shared by the blend core.
// ----------------------------------------------------------------------------
package awpb_pkg;

  localparam int unsigned CH_N    = 3;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned FACT_W  = 9;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned STAGE_N = 6;

  localparam logic [FACT_W-1:0] BLEND_ONE   = 9'd256;
  localparam logic [FACT_W-1:0] BLEND_RESET = 9'd51;

  typedef logic [CH_N-1:0][PIX_W-1:0] awpb_pix_t;

  typedef struct packed {
    logic [WGT_W-1:0]                den;
    logic [CH_N-1:0][WGT_W-1:0]      rem;
    logic [CH_N-1:0][PIX_W-1:0]      lq;
  } awpb_div_t;

endpackage

[hw/rtl/alpha_weighted_pixel_blend_core.sv]
// Throughput: one pixel per clock unless stalled; six register stages (two
// for weights and products, four for the divider at two quotient bits each),
// each of which advances when it is empty or when the stage after it advances.
// Reset: rst_n is synchronous and active low; it empties the pipeline and
// loads the blend factor with 51.
// ----------------------------------------------------------------------------
// Alpha weighted pixel blend core
// Blends two BGRA pixels into one BGR pixel with alpha and blend factor weights.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alpha_weighted_pixel_blend_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [awpb_pkg::FACT_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [awpb_pkg::PIX_W-1:0]        in_first_blue,
  input  logic [awpb_pkg::PIX_W-1:0]        in_first_green,
  input  logic [awpb_pkg::PIX_W-1:0]        in_first_red,
  input  logic [awpb_pkg::PIX_W-1:0]        in_first_opacity,
  input  logic [awpb_pkg::PIX_W-1:0]        in_second_blue,
  input  logic [awpb_pkg::PIX_W-1:0]        in_second_green,
  input  logic [awpb_pkg::PIX_W-1:0]        in_second_red,
  input  logic [awpb_pkg::PIX_W-1:0]        in_second_opacity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [awpb_pkg::PIX_W-1:0]        out_blue,
  output logic [awpb_pkg::PIX_W-1:0]        out_green,
  output logic [awpb_pkg::PIX_W-1:0]        out_red
);

  logic [awpb_pkg::FACT_W-1:0]    blend_factor_r;
  logic [awpb_pkg::STAGE_N-1:0]   v;
  logic [awpb_pkg::STAGE_N-1:0]   en;
  awpb_pkg::awpb_div_t            div_q [0:4];
  awpb_pkg::awpb_pix_t            c1;
  awpb_pkg::awpb_pix_t            c2;
  logic                           zero_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_factor_r <= awpb_pkg::BLEND_RESET;
    end else if (cfg_wr_en) begin
      blend_factor_r <= cfg_wr_data;
    end
  end

  always_comb begin
    en[awpb_pkg::STAGE_N-1] = !v[awpb_pkg::STAGE_N-1] || !out_stall;
    for (int i = awpb_pkg::STAGE_N-2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign c1 = {in_first_red, in_first_green, in_first_blue};
  assign c2 = {in_second_red, in_second_green, in_second_blue};

  awpb_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[1:0]),
    .in_valid (in_valid),
    .factor   (blend_factor_r),
    .c1       (c1),
    .c2       (c2),
    .a1       (in_first_opacity),
    .a2       (in_second_opacity),
    .valid    (v[1:0]),
    .out_data (div_q[0])
  );

  for (genvar g = 0; g < 4; g++) begin : g_div
    awpb_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en[g+2]),
      .in_valid  (v[g+1]),
      .in_data   (div_q[g]),
      .out_valid (v[g+2]),
      .out_data  (div_q[g+1])
    );
  end

  assign zero_w    = (div_q[4].den == '0);
  assign out_valid = v[awpb_pkg::STAGE_N-1];
  assign out_blue  = zero_w ? '0 : div_q[4].lq[0];
  assign out_green = zero_w ? '0 : div_q[4].lq[1];
  assign out_red   = zero_w ? '0 : div_q[4].lq[2];

  `AWPB_ASSERT(a_stall_means_full, clk, rst_n, in_stall |-> (v == '1))
  `AWPB_ASSERT(a_last_stage_holds, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(div_q[4])))
  `AWPB_ASSERT(a_no_bubble_stall, clk, rst_n, (!v[0] && in_valid) |-> !in_stall)

endmodule

[hw/rtl/awpb_mac.sv]
// ----------------------------------------------------------------------------
// Blend weight and product stages
// Two register stages: alpha weights, then weighted channel sums and total.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module awpb_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          en,
  input  logic                                in_valid,
  input  logic [awpb_pkg::FACT_W-1:0]         factor,
  input  awpb_pkg::awpb_pix_t                 c1,
  input  awpb_pkg::awpb_pix_t                 c2,
  input  logic [awpb_pkg::PIX_W-1:0]          a1,
  input  logic [awpb_pkg::PIX_W-1:0]          a2,
  output logic [1:0]                          valid,
  output awpb_pkg::awpb_div_t                 out_data
);

  logic                               v1_r;
  logic                               v2_r;
  logic [awpb_pkg::WGT_W-1:0]         w1_r;
  logic [awpb_pkg::WGT_W-1:0]         w2_r;
  awpb_pkg::awpb_pix_t                c1_r;
  awpb_pkg::awpb_pix_t                c2_r;
  awpb_pkg::awpb_div_t                div_r;

  logic [awpb_pkg::FACT_W-1:0]        k;
  logic [awpb_pkg::FACT_W-1:0]        k_inv;
  logic [awpb_pkg::WGT_W:0]           p1;
  logic [awpb_pkg::WGT_W:0]           p2;
  logic [awpb_pkg::WGT_W:0]           tot;
  awpb_pkg::awpb_div_t                div_nxt;
  logic [awpb_pkg::NUM_W-1:0]         m1;
  logic [awpb_pkg::NUM_W-1:0]         m2;
  logic [awpb_pkg::NUM_W-1:0]         num;

  always_comb begin
    k     = (factor > awpb_pkg::BLEND_ONE) ? awpb_pkg::BLEND_ONE : factor;
    k_inv = awpb_pkg::BLEND_ONE - k;
    p1    = 17'(a1) * 17'(k);
    p2    = 17'(a2) * 17'(k_inv);
  end

  always_comb begin
    m1  = '0;
    m2  = '0;
    num = '0;
    tot = 17'(w1_r) + 17'(w2_r);
    div_nxt.den = tot[awpb_pkg::WGT_W-1:0];
    for (int i = 0; i < awpb_pkg::CH_N; i++) begin
      m1  = 24'(c1_r[i]) * 24'(w1_r);
      m2  = 24'(c2_r[i]) * 24'(w2_r);
      num = m1 + m2;
      div_nxt.rem[i] = num[awpb_pkg::NUM_W-1:awpb_pkg::PIX_W];
      div_nxt.lq[i]  = num[awpb_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en[0]) begin
        v1_r <= in_valid;
      end
      if (en[1]) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      w1_r <= p1[awpb_pkg::WGT_W-1:0];
      w2_r <= p2[awpb_pkg::WGT_W-1:0];
      c1_r <= c1;
      c2_r <= c2;
    end
    if (en[1] && v1_r) begin
      div_r <= div_nxt;
    end
  end

  assign valid    = {v2_r, v1_r};
  assign out_data = div_r;

  `AWPB_ASSERT_NEVER(a_zero_weight_zero_sum, clk, rst_n, v2_r && (div_r.den == '0) && ((div_r.rem != '0) || (div_r.lq != '0)))

endmodule

[hw/rtl/awpb_div_stage.sv]
// ----------------------------------------------------------------------------
// Divider stage
// One register stage of the restoring divider: two quotient bits per channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module awpb_div_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  awpb_pkg::awpb_div_t  in_data,
  output logic                 out_valid,
  output awpb_pkg::awpb_div_t  out_data
);

  logic                 v_r;
  awpb_pkg::awpb_div_t  data_r;
  awpb_pkg::awpb_div_t  data_nxt;

  function automatic awpb_pkg::awpb_div_t div_step(input awpb_pkg::awpb_div_t d);
    awpb_pkg::awpb_div_t     r;
    logic [awpb_pkg::WGT_W:0] trial;
    logic [awpb_pkg::WGT_W:0] diff;
    logic                     ge;
    r = d;
    for (int i = 0; i < awpb_pkg::CH_N; i++) begin
      trial   = {d.rem[i], d.lq[i][awpb_pkg::PIX_W-1]};
      diff    = trial - 17'(d.den);
      ge      = (trial >= 17'(d.den));
      r.rem[i] = ge ? diff[awpb_pkg::WGT_W-1:0] : trial[awpb_pkg::WGT_W-1:0];
      r.lq[i]  = {d.lq[i][awpb_pkg::PIX_W-2:0], ge};
    end
    return r;
  endfunction

  assign data_nxt = div_step(div_step(in_data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

  `AWPB_ASSERT(a_rem_below_den, clk, rst_n, v_r |-> ((data_r.den == '0) || ((data_r.rem[0] < data_r.den) && (data_r.rem[1] < data_r.den) && (data_r.rem[2] < data_r.den))))

endmodule
